// ===== hw/rtl/csht_pkg.sv =====
// ----------------------------------------------------------------------------
// csht_pkg: shared types and constants
// Operation and status codes, and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package csht_pkg;

    localparam int KEY_CHARS = 7;
    localparam int KEY_W     = 8 * KEY_CHARS;
    localparam int CHAR_W    = 7;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_CHARS{8'h7F}};

    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_POOL    = 1024;

    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_W-1:0] BCOUNT_RST = 11'd1024;
    localparam logic [7:0]       HBASE_RST  = 8'd53;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BCOUNT = 1'b0,
        REG_HBASE  = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_COUNT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic clr;        // clearing pass step
        logic load;       // latch the input request
        logic hash_start;
        logic walk_init;  // latch chain head, length and free stack top
        logic advance;    // move to the next node of the chain
        logic set_miss;
        logic set_full;
        logic ins;
        logic del;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic hash_done;
        logic clr_last;
        logic pool_empty;
        logic chain_end;
        logic key_match;
    } t_dp_stat;

endpackage

// ===== hw/rtl/csht_hash.sv =====
// ----------------------------------------------------------------------------
// csht_hash: iterative polynomial hash
// Horner form, one character per round: a multiply step, then a bit-serial
// restoring remainder by the bucket modulus.
// ----------------------------------------------------------------------------
module csht_hash
    import csht_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    localparam int BW  = $clog2(BUCKETS),
    localparam int MW  = $clog2(BUCKETS + 1),
    localparam int XW  = BW + 9,
    localparam int XBW = $clog2(XW)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic [7:0]       i_base,
    input  logic [MW-1:0]    i_mod,
    output logic             o_done,
    output logic [BW-1:0]    o_hash
);

    logic             r_busy, r_mul;
    logic [2:0]       r_ci;
    logic [XBW-1:0]   r_bit;
    logic [XW-1:0]    r_x;
    logic [MW-1:0]    r_rem;
    logic [BW-1:0]    r_h;
    logic [KEY_W-1:0] r_key;
    logic             r_done;

    logic [CHAR_W-1:0] c;
    logic [MW:0]       rem_sh, rem_nx;

    assign c      = r_key[{r_ci, 3'b000} +: CHAR_W];
    assign rem_sh = {r_rem, r_x[r_bit]};
    assign rem_nx = (rem_sh >= {1'b0, i_mod}) ? rem_sh - {1'b0, i_mod} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mul  <= 1'b1;
                r_ci   <= 3'(KEY_CHARS - 1);
                r_h    <= '0;
                r_key  <= i_key;
            end else if (r_busy) begin
                if (r_mul) begin
                    r_x   <= XW'(r_h) * XW'(i_base) + XW'(c);
                    r_rem <= '0;
                    r_bit <= XBW'(XW - 1);
                    r_mul <= 1'b0;
                end else begin
                    r_rem <= rem_nx[MW-1:0];
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_h   <= rem_nx[BW-1:0];
                        r_mul <= 1'b1;
                        r_ci  <= r_ci - 1'b1;
                        if (r_ci == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h;

endmodule

// ===== hw/rtl/csht_datapath.sv =====
// ----------------------------------------------------------------------------
// csht_datapath: table memories and working registers
// Chain heads and lengths per bucket, node keys and links, the free-node
// stack, the counters, and the hash unit.
// ----------------------------------------------------------------------------
module csht_datapath
    import csht_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int POOL    = DEF_POOL,
    localparam int BW   = $clog2(BUCKETS),
    localparam int MW   = $clog2(BUCKETS + 1),
    localparam int PW   = $clog2(POOL),
    localparam int LW   = $clog2(POOL + 1),
    localparam int MAXD = (BUCKETS > POOL) ? BUCKETS : POOL,
    localparam int CLRW = $clog2(MAXD)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [1:0]       i_op,
    input  logic [KEY_W-1:0] i_key,
    input  logic [7:0]       i_base,
    input  logic [MW-1:0]    i_mod,
    output t_dp_stat         o_stat,
    output logic [1:0]       o_status,
    output logic [BW-1:0]    o_bucket,
    output logic [MW-1:0]    o_crowded
);

    logic [PW-1:0]    head_mem [BUCKETS];
    logic [LW-1:0]    len_mem  [BUCKETS];
    logic [KEY_W-1:0] key_mem  [POOL];
    logic [PW-1:0]    link_mem [POOL];
    logic [PW-1:0]    free_mem [POOL];

    logic [PW-1:0]    head_q, link_q, free_q;
    logic [LW-1:0]    len_q;
    logic [KEY_W-1:0] key_q;

    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    t_status          r_status;
    logic [BW-1:0]    r_bucket;
    logic [MW-1:0]    r_crowded;
    logic [LW-1:0]    r_ft;
    logic [CLRW-1:0]  r_clr;
    logic [PW-1:0]    r_cur, r_prev, r_fidx;
    logic [LW-1:0]    r_k, r_len;

    logic [KEY_W-1:0] key_c;
    logic             hash_done;
    logic [BW-1:0]    hash_val;
    logic             clr_b;
    logic [LW-1:0]    len_up, len_dn;

    assign key_c  = i_key & KEY_MASK;
    assign clr_b  = 32'(r_clr) < BUCKETS;
    assign len_up = r_len + 1'b1;
    assign len_dn = r_len - 1'b1;

    csht_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hash_start),
        .i_key   (key_c),
        .i_base  (i_base),
        .i_mod   (i_mod),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    // bucket memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins || (i_cmd.del && r_k == '0))
            head_mem[r_bucket] <= i_cmd.ins ? r_fidx : link_q;
        head_q <= head_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && clr_b)
            len_mem[r_clr[BW-1:0]] <= '0;
        else if (i_cmd.ins)
            len_mem[r_bucket] <= len_up;
        else if (i_cmd.del)
            len_mem[r_bucket] <= len_dn;
        len_q <= len_mem[r_bucket];
    end

    // node memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins)
            key_mem[r_fidx] <= r_key;
        key_q <= key_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins)
            link_mem[r_fidx] <= head_q;
        else if (i_cmd.del && r_k != '0)
            link_mem[r_prev] <= link_q;
        link_q <= link_mem[r_cur];
    end

    // free-node stack, filled with every index by the clearing pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && 32'(r_clr) < POOL)
            free_mem[r_clr[PW-1:0]] <= r_clr[PW-1:0];
        else if (i_cmd.del && 32'(r_ft) < POOL)
            free_mem[r_ft[PW-1:0]] <= r_cur;
        free_q <= free_mem[PW'(r_ft - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_ft      <= LW'(POOL);
            r_crowded <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.ins) begin
                r_ft <= r_ft - 1'b1;
                if (len_up == LW'(2)) r_crowded <= r_crowded + 1'b1;
            end
            if (i_cmd.del) begin
                if (32'(r_ft) < POOL) r_ft <= r_ft + 1'b1;
                if (len_dn == LW'(1)) r_crowded <= r_crowded - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_key    <= key_c;
            r_status <= ST_OK;
            r_bucket <= '0;
        end
        if (hash_done) r_bucket <= hash_val;
        if (i_cmd.walk_init) begin
            r_cur  <= head_q;
            r_len  <= len_q;
            r_k    <= '0;
            r_fidx <= free_q;
        end
        if (i_cmd.advance) begin
            r_prev <= r_cur;
            r_cur  <= link_q;
            r_k    <= r_k + 1'b1;
        end
        if (i_cmd.set_miss) r_status <= ST_MISS;
        if (i_cmd.set_full) r_status <= ST_FULL;
    end

    assign o_stat.op         = r_op;
    assign o_stat.hash_done  = hash_done;
    assign o_stat.clr_last   = r_clr == CLRW'(MAXD - 1);
    assign o_stat.pool_empty = r_ft == '0;
    assign o_stat.chain_end  = r_k == r_len;
    assign o_stat.key_match  = key_q == r_key;

    assign o_status  = r_status;
    assign o_bucket  = r_bucket;
    assign o_crowded = r_crowded;

endmodule

// ===== hw/rtl/csht_ctrl.sv =====
// ----------------------------------------------------------------------------
// csht_ctrl: request sequencer
// Clearing pass, hash, bucket read, chain walk, update and hand-off.
// ----------------------------------------------------------------------------
module csht_ctrl
    import csht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_op,
    input  logic       i_out_free,
    input  t_dp_stat   i_stat,
    output t_cmd       o_cmd,
    output logic       o_ready,
    output logic       o_busy,
    output logic       o_out_load
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_HASH  = 10'b0000000100,
        S_BKT   = 10'b0000001000,
        S_BKTW  = 10'b0000010000,
        S_NODE  = 10'b0000100000,
        S_CMP   = 10'b0001000000,
        S_INS   = 10'b0010000000,
        S_DEL   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_ready    = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (t_op'(i_in_op) == OP_COUNT) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.hash_start = 1'b1;
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) n_state = S_BKT;
            end
            S_BKT: n_state = S_BKTW;
            S_BKTW: begin
                o_cmd.walk_init = 1'b1;
                if (i_stat.op != OP_INSERT) begin
                    n_state = S_NODE;
                end else if (i_stat.pool_empty) begin
                    o_cmd.set_full = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS;
                end
            end
            S_NODE: begin
                if (i_stat.chain_end) begin
                    o_cmd.set_miss = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_stat.key_match) begin
                    o_cmd.advance = 1'b1;
                    n_state = S_NODE;
                end else if (i_stat.op == OP_DELETE) begin
                    n_state = S_DEL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state = S_DONE;
            end
            S_DEL: begin
                o_cmd.del = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_busy = r_state != S_IDLE;

endmodule

// ===== hw/rtl/chained_string_hash_table.sv =====
// ----------------------------------------------------------------------------
// chained_string_hash_table: separate-chaining hash table, 7-char keys
// Insert, search, delete and crowded-bucket query over a finite node pool.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests come in on the s_axis group: tdata = {key[55:0], operation[1:0]}
//    (operation 0 insert, 1 search, 2 delete, 3 crowded-bucket count).
//  - Results leave on the m_axis group: tdata = {crowded_buckets, bucket,
//    status}; status 0 done/found, 1 not found, 2 pool full.
//  - One request is in flight at a time. Operation 3 goes straight to the
//    result; the others run the hash, whose time is set by the bit-serial
//    remainder in the hash unit, then the bucket read and a walk that
//    compares one chain node at a time; a delete hit adds an unlink step.
//  - The result sits in an output register; the next request is taken as
//    soon as the sequencer is back in idle, even while that result waits.
//    A stalled receiver holds the sequencer at hand-off once a second result
//    is ready.
//  - After reset a clearing pass zeroes the chain lengths and refills the
//    free-node stack; s_axis tready is low for that time. Configuration
//    writes are taken at any time.
//  - Config: register 0 bucket_count (0 acts as 1, saturates at BUCKETS),
//    register 1 hash_base.
// ----------------------------------------------------------------------------
module chained_string_hash_table
    import csht_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int POOL    = DEF_POOL
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // operation[1:0], key[57:2], zero
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // status[1:0], bucket[11:2],
                                                    // crowded_buckets[22:12], zero
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    localparam int BW = $clog2(BUCKETS);
    localparam int MW = $clog2(BUCKETS + 1);

    logic [CFG_W-1:0] r_bcount;
    logic [7:0]       r_hbase;
    logic [MW-1:0]    eff_mod;

    t_cmd       cmd;
    t_dp_stat   stat;
    logic       ready, busy, out_load, out_free;
    logic [1:0] dp_status;
    logic [BW-1:0] dp_bucket;
    logic [MW-1:0] dp_crowded;

    logic                   r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount <= BCOUNT_RST;
            r_hbase  <= HBASE_RST;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_BCOUNT: r_bcount <= i_cfg_wdata;
                REG_HBASE:  r_hbase  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // modulus in use: zero acts as one, large values saturate
    always_comb begin
        if (r_bcount == '0)              eff_mod = MW'(1);
        else if (32'(r_bcount) > BUCKETS) eff_mod = MW'(BUCKETS);
        else                             eff_mod = MW'(r_bcount);
    end

    csht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tdata[1:0]),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_ready    (ready),
        .o_busy     (busy),
        .o_out_load (out_load)
    );

    csht_datapath #(.BUCKETS(BUCKETS), .POOL(POOL)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_op      (i_s_axis_tdata[1:0]),
        .i_key     (i_s_axis_tdata[KEY_W+1:2]),
        .i_base    (r_hbase),
        .i_mod     (eff_mod),
        .o_stat    (stat),
        .o_status  (dp_status),
        .o_bucket  (dp_bucket),
        .o_crowded (dp_crowded)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !r_ovalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load)
            r_odata <= {1'b0, 11'(dp_crowded), 10'(dp_bucket), dp_status};
    end

    assign o_s_axis_tready = ready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // one request at a time: the sequencer leaves idle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while another is in flight");

    // a result is loaded only from the hand-off step of a busy sequencer
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (busy && out_free))
        else $error("result loaded outside hand-off");

    // no result while the clearing pass runs
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr |-> !o_m_axis_tvalid)
        else $error("result during clearing pass");

    // status codes stay within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] == ST_OK ||
                             o_m_axis_tdata[1:0] == ST_MISS ||
                             o_m_axis_tdata[1:0] == ST_FULL))
        else $error("undefined status code");

endmodule

// ===== bench/tb_chained_string_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_string_hash_table: self-checking bench for the chained hash table
// A directed table of requests, then random request traffic, each checked
// against a behavioral table model; both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_chained_string_hash_table;
    import csht_pkg::*;

    localparam int NB = 1024;
    localparam int NP = 1024;
    localparam int WDOG_LIMIT = 20000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    chained_string_hash_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- table model ----------------
    // lowest field last: matches the m_axis tdata packing
    typedef struct packed {
        logic [10:0] crowded;
        logic [9:0]  bucket;
        logic [1:0]  status;
    } t_result;

    logic [10:0] mdl_bcount;
    logic [7:0]  mdl_base;
    int unsigned head_q [NB];
    int unsigned len_q  [NB];
    logic [55:0] nkey   [NP];
    int unsigned nlink  [NP];
    int unsigned free_stk [NP];
    int unsigned free_cnt;
    int unsigned crowd_cnt;

    t_result pending_q [$];
    int unsigned err_cnt = 0;

    // keys recently inserted, reused so search/delete hit
    logic [55:0] key_pool [$];

    task automatic table_reset();
        mdl_bcount = BCOUNT_RST;
        mdl_base   = HBASE_RST;
        for (int i = 0; i < NB; i++) begin
            head_q[i] = 0;
            len_q[i]  = 0;
        end
        for (int i = 0; i < NP; i++) free_stk[i] = i;
        free_cnt  = NP;
        crowd_cnt = 0;
    endtask

    function automatic int unsigned key_bucket(logic [55:0] k);
        longint unsigned h, m;
        h = 0;
        m = (mdl_bcount == 0) ? 1 : (mdl_bcount > NB) ? NB : mdl_bcount;
        for (int i = KEY_CHARS - 1; i >= 0; i--)
            h = (h * mdl_base + k[8*i +: 7]) % m;
        return int'(h);
    endfunction

    function automatic t_result table_apply(t_op op, logic [55:0] raw);
        t_result r;
        logic [55:0] k;
        int unsigned b, cur, prev, n, j;
        bit found;
        k = raw & KEY_MASK;
        r.status = ST_OK;
        b = 0;
        if (op != OP_COUNT) begin
            b = key_bucket(k);
            if (op == OP_INSERT) begin
                if (free_cnt == 0) begin
                    r.status = ST_FULL;
                end else begin
                    free_cnt--;
                    n = free_stk[free_cnt];
                    nkey[n] = k;
                    nlink[n] = head_q[b];
                    head_q[b] = n;
                    len_q[b]++;
                    if (len_q[b] == 2) crowd_cnt++;
                end
            end else begin
                cur = head_q[b];
                prev = 0;
                found = 0;
                for (j = 0; j < len_q[b]; j++) begin
                    if (nkey[cur] == k) begin
                        found = 1;
                        break;
                    end
                    prev = cur;
                    cur = nlink[cur];
                end
                if (!found) begin
                    r.status = ST_MISS;
                end else if (op == OP_DELETE) begin
                    if (j == 0) head_q[b] = nlink[cur];
                    else nlink[prev] = nlink[cur];
                    len_q[b]--;
                    if (len_q[b] == 1) crowd_cnt--;
                    if (free_cnt < NP) begin
                        free_stk[free_cnt] = cur;
                        free_cnt++;
                    end
                end
            end
        end
        r.bucket  = b[9:0];
        r.crowded = crowd_cnt[10:0];
        return r;
    endfunction

    // ---------------- directed table ----------------
    typedef struct {
        t_op         op;
        logic [55:0] key;
        bit          fixed;     // expected result typed in below
        t_result     res;
    } t_row;

    t_row dir_rows [$];

    task automatic add_row(t_op op, logic [55:0] k, bit fx = 0,
                           logic [1:0] st = 0, logic [9:0] bk = 0,
                           logic [10:0] cr = 0);
        t_row r;
        r.op = op; r.key = k; r.fixed = fx;
        r.res.status = st; r.res.bucket = bk; r.res.crowded = cr;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // ---------------- sender ----------------
    // tvalid stays high into a back-to-back request; drain_wait drops it
    task automatic send_request(t_op op, logic [55:0] k, bit fixed, t_result fx);
        int gap;
        t_result r;
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r = table_apply(op, k);
        if (fixed && r != fx) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("table row mismatch: op %0d key %h typed %h model %h",
                         op, k, fx, r);
        end
        pending_q.insert(pending_q.size(), r);
        s_tdata  <= {6'd0, k, op};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [10:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_BCOUNT) mdl_bcount = v;
        else mdl_base = v[7:0];
    endtask

    function automatic logic [55:0] rand_key();
        return 56'({$urandom(), $urandom()});
    endfunction

    // draws a key, mostly from a small alphabet so chains collide
    function automatic logic [55:0] pick_key();
        int sel;
        logic [55:0] flip;
        sel = $urandom_range(0, 9);
        flip = {1'($urandom_range(0, 1)), 55'd0} | (56'h80 & {56{sel == 0}});
        if (sel < 5 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)] ^ flip;
        if (sel < 8) return {48'd0, 8'($urandom_range(0, 15))};
        return rand_key();
    endfunction

    // ---------------- receiver / checker ----------------
    initial begin
        t_result got, want;
        int stall;
        forever begin
            stall = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            got = t_result'(m_tdata[22:0]);
            if (pending_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_q.pop_front();
                if (got.status !== want.status || got.bucket !== want.bucket ||
                    got.crowded !== want.crowded) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: status %0d/%0d bucket %0d/%0d crowded %0d/%0d",
                                 want.status, got.status, want.bucket, got.bucket,
                                 want.crowded, got.crowded);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int unsigned idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        logic [55:0] k;
        t_op op;
        int r;
        t_result none;
        none = '0;
        table_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: empty table, all-zero key hashes to bucket 0
        add_row(OP_COUNT,  56'd0, 1, ST_OK, 0, 0);
        add_row(OP_SEARCH, 56'd0, 1, ST_MISS, 0, 0);
        add_row(OP_DELETE, 56'd0, 1, ST_MISS, 0, 0);
        add_row(OP_INSERT, 56'd0, 1, ST_OK, 0, 0);
        add_row(OP_INSERT, 56'd0, 1, ST_OK, 0, 1);  // duplicate
        // bit 7 of every char ignored: all-ones key equals 0x7F chars
        add_row(OP_INSERT, {56{1'b1}});
        add_row(OP_SEARCH, {7{8'h7F}});
        add_row(OP_SEARCH, {7{8'h80}}, 1, ST_OK, 0, 1);
        add_row(OP_DELETE, 56'd0, 1, ST_OK, 0, 0);
        add_row(OP_DELETE, 56'd0, 1, ST_OK, 0, 0);
        add_row(OP_DELETE, 56'd0, 1, ST_MISS, 0, 0);
        add_row(OP_INSERT, 56'h02030405060708);
        add_row(OP_SEARCH, 56'h02030405060708);
        add_row(OP_DELETE, {7{8'h7F}});
        add_row(OP_COUNT,  {56{1'b1}});
        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].fixed,
                         dir_rows[i].res);
        drain_wait();

        // bucket count zero acts as one bucket: everything lands in bucket 0
        write_reg(REG_BCOUNT, 11'd0);
        write_reg(REG_HBASE, 11'd0);
        send_request(OP_INSERT, 56'h00AABBCC, 0, none);
        send_request(OP_SEARCH, 56'h00112233, 0, none);
        drain_wait();
        // above the bucket array saturates; base 1 is a plain char sum
        write_reg(REG_BCOUNT, 11'h7FF);
        write_reg(REG_HBASE, 11'd1);
        send_request(OP_INSERT, {7{8'h7F}}, 0, none);
        send_request(OP_SEARCH, {7{8'h7F}}, 0, none);
        drain_wait();

        // random phases over several settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(REG_BCOUNT, 11'd1);    write_reg(REG_HBASE, 11'd2);   end
                1: begin write_reg(REG_BCOUNT, 11'd1024); write_reg(REG_HBASE, 11'd255); end
                2: begin write_reg(REG_BCOUNT, 11'd7);    write_reg(REG_HBASE, 11'd53);  end
                3: begin write_reg(REG_BCOUNT, 11'd2);    write_reg(REG_HBASE, 11'd129); end
                default: begin
                    write_reg(REG_BCOUNT, 11'($urandom_range(0, 2047)));
                    write_reg(REG_HBASE, 11'($urandom_range(0, 255)));
                end
            endcase
            for (int n = 0; n < 30; n++) begin
                r = $urandom_range(0, 99);
                op = (r < 45) ? OP_INSERT : (r < 70) ? OP_SEARCH :
                     (r < 95) ? OP_DELETE : OP_COUNT;
                k = pick_key();
                if (op == OP_INSERT) begin
                    key_pool.insert(key_pool.size(), k);
                    if (key_pool.size() > 40) void'(key_pool.pop_front());
                end
                send_request(op, k, 0, none);
                if (n == 15) drain_wait();  // sender holds off until drained
            end
            drain_wait();
        end

        // fill the pool to the brim, then one pool-full insert
        write_reg(REG_BCOUNT, 11'd1024);
        write_reg(REG_HBASE, 11'd53);
        while (free_cnt != 0) send_request(OP_INSERT, rand_key(), 0, none);
        send_request(OP_INSERT, rand_key(), 0, none);
        drain_wait();

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
